// File: sv/wcrc_pkg.sv
// Shared types, constants and helper functions for the word CRC-32 engine.
package wcrc_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TBL_CW = $clog2(WORD_W) + 1;
  localparam int unsigned CFG_AW = 4;

  localparam logic [WORD_W-1:0] POLY_RST = 32'h04C1_1DB7;
  localparam logic [WORD_W-1:0] INIT_RST = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0] MASK_RST = 32'hFFFF_FFFF;
  localparam logic              REFL_RST = 1'b0;

  typedef enum logic [1:0] {
    REG_POLY = 2'd0,
    REG_INIT = 2'd1,
    REG_MASK = 2'd2,
    REG_REFL = 2'd3
  } reg_idx_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_FOLD = 1'b1
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              last;
    logic [WORD_W-1:0] data;
  } item_t;

  function automatic logic [WORD_W-1:0] bswap32(input logic [WORD_W-1:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic logic [WORD_W-1:0] brev32(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] r;
    for (int i = 0; i < WORD_W; i++) begin
      r[i] = v[WORD_W-1-i];
    end
    return r;
  endfunction

  // one MSB-first shift of the CRC register
  function automatic logic [WORD_W-1:0] crc_step(input logic [WORD_W-1:0] v,
                                                 input logic [WORD_W-1:0] poly);
    return v[WORD_W-1] ? ({v[WORD_W-2:0], 1'b0} ^ poly) : {v[WORD_W-2:0], 1'b0};
  endfunction

endpackage

// File: sv/wcrc_front.sv
// Front stage: takes input words, classifies them and prepares the data word.
module wcrc_front import wcrc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [WORD_W-1:0] in_data_word,
  input  logic              in_first_word,
  input  logic              in_last_word,
  input  logic              reflect,
  output logic              q_push,
  output item_t             q_item,
  input  logic              q_full
);

  logic  stg_v_r, stg_v_nxt;
  item_t stg_r, stg_nxt;
  logic  take;
  logic [WORD_W-1:0] swapped;

  assign full   = stg_v_r && q_full;
  assign take   = push && !full;
  assign q_push = stg_v_r && !q_full;
  assign q_item = stg_r;

  always_comb begin
    swapped = bswap32(in_data_word);
    stg_nxt = stg_r;
    stg_v_nxt = stg_v_r;
    if (q_push) begin
      stg_v_nxt = 1'b0;
    end
    if (take) begin
      stg_v_nxt = 1'b1;
      stg_nxt.op = in_first_word ? OP_LOAD : OP_FOLD;
      stg_nxt.last = in_last_word;
      stg_nxt.data = reflect ? brev32(swapped) : swapped;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else begin
      stg_v_r <= stg_v_nxt;
    end
    stg_r <= stg_nxt;
  end

endmodule

// File: sv/wcrc_fifo.sv
// Short item queue between the front and back stages.
module wcrc_fifo import wcrc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr,
  input  item_t wr_item,
  output logic  full,
  input  logic  rd,
  output item_t rd_item,
  output logic  empty
);

  item_t mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wp_r, rp_r;
  logic [QUEUE_CW-1:0] cnt_r;
  logic do_wr, do_rd;

  assign full    = (cnt_r == QUEUE_CW'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_item = mem[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_rd) begin
        rp_r <= rp_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
    if (do_wr) begin
      mem[wp_r] <= wr_item;
    end
  end

endmodule

// File: sv/wcrc_back.sv
// Back stage: CRC register, per-polynomial fold columns and result register.
module wcrc_back import wcrc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [WORD_W-1:0] poly,
  input  logic [WORD_W-1:0] init,
  input  logic [WORD_W-1:0] mask,
  input  logic              reflect,
  input  logic              tbl_start,
  input  logic [WORD_W-1:0] tbl_seed,
  input  item_t             q_item,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              empty,
  input  logic              pop,
  output logic [WORD_W-1:0] out_crc_result
);

  // col_r[j] is the fold of a lone set bit j: x^(32+j) mod P
  logic [WORD_W-1:0] col_r [WORD_W];
  logic [WORD_W-1:0] seed_r, seed_nxt;
  logic [TBL_CW-1:0] tcnt_r, tcnt_nxt;
  logic              tbl_rdy;

  logic [WORD_W-1:0] crc_r, crc_nxt;
  logic [WORD_W-1:0] res_r, res_nxt;
  logic              res_v_r, res_v_nxt;
  logic [WORD_W-1:0] mix, folded;
  logic              out_take;

  assign tbl_rdy        = tcnt_r[TBL_CW-1];
  assign empty          = !res_v_r;
  assign out_crc_result = res_r;
  assign out_take       = pop && res_v_r;
  assign q_pop = !q_empty && tbl_rdy && (!q_item.last || !res_v_r || out_take);

  always_comb begin
    tcnt_nxt = tcnt_r;
    seed_nxt = seed_r;
    if (tbl_start) begin
      tcnt_nxt = '0;
      seed_nxt = tbl_seed;
    end else if (!tbl_rdy) begin
      tcnt_nxt = tcnt_r + 1'b1;
      seed_nxt = crc_step(seed_r, poly);
    end
  end

  always_comb begin
    mix = crc_r ^ q_item.data;
    folded = '0;
    for (int j = 0; j < WORD_W; j++) begin
      folded = folded ^ (mix[j] ? col_r[j] : '0);
    end
  end

  always_comb begin
    crc_nxt   = crc_r;
    res_nxt   = res_r;
    res_v_nxt = res_v_r;
    if (out_take) begin
      res_v_nxt = 1'b0;
    end
    if (q_pop) begin
      case (q_item.op)
        OP_LOAD: crc_nxt = init;
        OP_FOLD: crc_nxt = folded;
        default: crc_nxt = crc_r;
      endcase
      if (q_item.last) begin
        res_v_nxt = 1'b1;
        res_nxt = (reflect ? brev32(crc_nxt) : crc_nxt) ^ mask;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tcnt_r  <= '0;
      seed_r  <= POLY_RST;
      crc_r   <= INIT_RST;
      res_v_r <= 1'b0;
    end else begin
      tcnt_r  <= tcnt_nxt;
      seed_r  <= seed_nxt;
      crc_r   <= crc_nxt;
      res_v_r <= res_v_nxt;
    end
    res_r <= res_nxt;
    if (!tbl_rdy && !tbl_start) begin
      col_r[tcnt_r[TBL_CW-2:0]] <= seed_r;
    end
  end

endmodule

// File: sv/word_crc32_engine_unit.sv
// Word CRC-32 engine top level: configuration registers, front, queue and back.
// A last word's result passes the front staging register and the queue before the result register; stalls can hold it.
// Throughput: one word per cycle while nothing stalls; the CRC register folds a whole word per cycle
// through a 32-column XOR network.
// Reset: synchronous, active low; after reset and after each polynomial write the
// 32 fold columns are rebuilt one after another, during which words queue but are not folded.
module word_crc32_engine_unit import wcrc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [WORD_W-1:0] in_data_word,
  input  logic              in_first_word,
  input  logic              in_last_word,
  output logic              empty,
  input  logic              pop,
  output logic [WORD_W-1:0] out_crc_result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [WORD_W-1:0] pwdata,
  output logic [WORD_W-1:0] prdata,
  output logic              pready
);

  logic [WORD_W-1:0] poly_r, init_r, mask_r;
  logic              refl_r;
  logic              wr_en, poly_wr;
  reg_idx_t          idx;

  logic  q_push, q_full, q_pop, q_empty;
  item_t q_in, q_out;

  assign pready  = 1'b1;
  assign idx     = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;
  assign poly_wr = wr_en && (idx == REG_POLY);

  always_comb begin
    case (idx)
      REG_POLY: prdata = poly_r;
      REG_INIT: prdata = init_r;
      REG_MASK: prdata = mask_r;
      REG_REFL: prdata = {{(WORD_W-1){1'b0}}, refl_r};
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r <= POLY_RST;
      init_r <= INIT_RST;
      mask_r <= MASK_RST;
      refl_r <= REFL_RST;
    end else if (wr_en) begin
      case (idx)
        REG_POLY: poly_r <= pwdata;
        REG_INIT: init_r <= pwdata;
        REG_MASK: mask_r <= pwdata;
        REG_REFL: refl_r <= pwdata[0];
        default:  ;
      endcase
    end
  end

  wcrc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_data_word  (in_data_word),
    .in_first_word (in_first_word),
    .in_last_word  (in_last_word),
    .reflect       (refl_r),
    .q_push        (q_push),
    .q_item        (q_in),
    .q_full        (q_full)
  );

  wcrc_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_push),
    .wr_item (q_in),
    .full    (q_full),
    .rd      (q_pop),
    .rd_item (q_out),
    .empty   (q_empty)
  );

  wcrc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .poly           (poly_r),
    .init           (init_r),
    .mask           (mask_r),
    .reflect        (refl_r),
    .tbl_start      (poly_wr),
    .tbl_seed       (pwdata),
    .q_item         (q_out),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .out_crc_result (out_crc_result)
  );

endmodule
